/* hw/rtl/spq_pkg.sv */
package spq_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 5;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // Operation token that walks the cell chain one cell per cycle.
   // found: remove has matched, or insert has started displacing entries.
   // live: the token still changes cells it passes.
   typedef struct packed {
      logic                        active;
      logic                        live;
      logic                        remove;
      logic                        found;
      logic signed [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0]        payload;
   } tok_type;

endpackage

/* hw/rtl/spq_cell.sv */
module spq_cell
   import spq_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CW-1:0]           count,
   input  tok_type                 tok_in,
   output tok_type                 tok_out,
   input  logic signed [KEY_W-1:0] nbr_key,
   input  logic [PAYLOAD_W-1:0]    nbr_payload,
   output logic signed [KEY_W-1:0] ent_key,
   output logic [PAYLOAD_W-1:0]    ent_payload
);

   localparam logic [CW-1:0] IDX_W = CW'(IDX);

   logic signed [KEY_W-1:0] ent_key_ff;
   logic signed [KEY_W-1:0] ent_key_in;
   logic [PAYLOAD_W-1:0]    ent_payload_ff;
   logic [PAYLOAD_W-1:0]    ent_payload_in;
   tok_type                 tok_ff;
   tok_type                 tok_next_in;
   logic                    occupied;
   logic                    at_end;

   assign occupied = (IDX_W < count);
   assign at_end   = (IDX_W == count);

   always_comb begin
      ent_key_in     = ent_key_ff;
      ent_payload_in = ent_payload_ff;
      tok_next_in    = tok_in;
      if (tok_in.active && tok_in.live) begin
         if (!tok_in.remove) begin
            if (occupied) begin
               // once displacing, shift every later entry right
               if (tok_in.found || (ent_key_ff > tok_in.key)) begin
                  ent_key_in          = tok_in.key;
                  ent_payload_in      = tok_in.payload;
                  tok_next_in.key     = ent_key_ff;
                  tok_next_in.payload = ent_payload_ff;
                  tok_next_in.found   = 1'b1;
               end
            end else if (at_end) begin
               ent_key_in       = tok_in.key;
               ent_payload_in   = tok_in.payload;
               tok_next_in.live = 1'b0;
            end
         end else if (occupied) begin
            if (tok_in.found) begin
               ent_key_in     = nbr_key;
               ent_payload_in = nbr_payload;
            end else if (ent_key_ff == tok_in.key) begin
               // carry the removed payload to the end of the chain
               ent_key_in          = nbr_key;
               ent_payload_in      = nbr_payload;
               tok_next_in.found   = 1'b1;
               tok_next_in.payload = ent_payload_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_next_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_key_ff     <= ent_key_in;
      ent_payload_ff <= ent_payload_in;
   end

   assign tok_out     = tok_ff;
   assign ent_key     = ent_key_ff;
   assign ent_payload = ent_payload_ff;

endmodule

/* hw/rtl/sorted_priority_queue_unit.sv */
// Sorted priority queue of up to DEPTH entries (signed key, opaque payload),
// kept in ascending key order; equal keys stay in arrival order.
// Request channel (req_*): action 0 inserts key/payload, action 1 removes the
// first entry whose key matches. A request is taken when req_valid is high
// and req_stall is low. Response channel (rsp_*): one response per request
// with status, removed payload, entry count and head entry.
// Each request walks a chain of DEPTH cells, one cell per cycle. Its token
// is held in a launch register and then in each cell, and its result moves
// through a finish register into the response register. No new request is
// taken before that: req_stall is high while a request is in flight or its
// result has not yet moved into the response register.
// A finished response waits in rsp_* while rsp_stall is high; the following
// request is still taken and walks the chain meanwhile, and its result is
// held until the response register frees.
// Synchronous reset empties the queue (count zero) and clears both channels;
// no clearing pass is needed.
module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic [PAYLOAD_W-1:0]    req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [PAYLOAD_W-1:0]    rsp_removed_payload,
   output logic [COUNT_W-1:0]      rsp_entry_count,
   output logic signed [KEY_W-1:0] rsp_head_key,
   output logic [PAYLOAD_W-1:0]    rsp_head_payload
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_W   = CW'(1);

   tok_type                 tok_chain [0:DEPTH];
   logic signed [KEY_W-1:0] key_chain [0:DEPTH];
   logic [PAYLOAD_W-1:0]    payload_chain [0:DEPTH];

   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic                    busy_ff;
   logic                    busy_in;
   tok_type                 launch_ff;
   tok_type                 launch_in;
   logic                    op_remove_ff;
   logic                    fin_valid_ff;
   logic                    fin_valid_in;
   logic [STATUS_W-1:0]     fin_status_ff;
   logic [PAYLOAD_W-1:0]    fin_removed_ff;
   logic [COUNT_W-1:0]      fin_count_ff;
   logic signed [KEY_W-1:0] fin_head_key_ff;
   logic [PAYLOAD_W-1:0]    fin_head_payload_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [PAYLOAD_W-1:0]    rsp_removed_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic signed [KEY_W-1:0] rsp_head_key_ff;
   logic [PAYLOAD_W-1:0]    rsp_head_payload_ff;

   logic                    req_accept;
   logic                    arrive;
   logic                    rsp_free;
   logic                    fin_move;
   tok_type                 done_tok;
   logic [CW-1:0]           count_new;
   logic [CW+COUNT_W-1:0]   count_ext;
   logic [STATUS_W-1:0]     status_new;
   logic [PAYLOAD_W-1:0]    removed_new;

   assign req_accept = req_valid && !busy_ff;
   assign req_stall  = busy_ff;

   assign tok_chain[0]         = launch_ff;
   assign key_chain[DEPTH]     = '0;
   assign payload_chain[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .count       (count_ff),
         .tok_in      (tok_chain[i]),
         .tok_out     (tok_chain[i+1]),
         .nbr_key     (key_chain[i+1]),
         .nbr_payload (payload_chain[i+1]),
         .ent_key     (key_chain[i]),
         .ent_payload (payload_chain[i])
      );
   end

   assign done_tok = tok_chain[DEPTH];
   assign arrive   = done_tok.active;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign fin_move = fin_valid_ff && rsp_free;

   always_comb begin
      launch_in         = '0;
      launch_in.active  = req_accept;
      launch_in.live    = !((req_action == ACT_INSERT) && (count_ff == DEPTH_W));
      launch_in.remove  = req_action;
      launch_in.found   = 1'b0;
      launch_in.key     = req_key;
      launch_in.payload = req_payload;
   end

   always_comb begin
      count_new   = count_ff;
      status_new  = ST_INSERTED;
      removed_new = '0;
      if (op_remove_ff == ACT_INSERT) begin
         if (count_ff == DEPTH_W) begin
            status_new = ST_FULL;
         end else begin
            count_new = count_ff + ONE_W;
         end
      end else if (done_tok.found) begin
         status_new  = ST_REMOVED;
         removed_new = done_tok.payload;
         count_new   = count_ff - ONE_W;
      end else if (count_ff == '0) begin
         status_new = ST_EMPTY;
      end else begin
         status_new = ST_NOTFOUND;
      end
   end

   assign count_ext = {{COUNT_W{1'b0}}, count_new};

   always_comb begin
      count_in = count_ff;
      if (arrive) begin
         count_in = count_new;
      end

      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (fin_move) begin
         busy_in = 1'b0;
      end

      fin_valid_in = fin_valid_ff;
      if (arrive) begin
         fin_valid_in = 1'b1;
      end else if (fin_move) begin
         fin_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fin_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         launch_ff    <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         launch_ff    <= launch_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_remove_ff <= req_action;
      end
      if (arrive) begin
         fin_status_ff  <= status_new;
         fin_removed_ff <= removed_new;
         fin_count_ff   <= count_ext[COUNT_W-1:0];
         if (count_new != '0) begin
            fin_head_key_ff     <= key_chain[0];
            fin_head_payload_ff <= payload_chain[0];
         end else begin
            fin_head_key_ff     <= '0;
            fin_head_payload_ff <= '0;
         end
      end
      if (fin_move) begin
         rsp_status_ff       <= fin_status_ff;
         rsp_removed_ff      <= fin_removed_ff;
         rsp_count_ff        <= fin_count_ff;
         rsp_head_key_ff     <= fin_head_key_ff;
         rsp_head_payload_ff <= fin_head_payload_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_removed_payload = rsp_removed_ff;
   assign rsp_entry_count     = rsp_count_ff;
   assign rsp_head_key        = rsp_head_key_ff;
   assign rsp_head_payload    = rsp_head_payload_ff;

endmodule
